// ----- rtl/core/csm_pkg.sv -----
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types, constants and fixed-point helpers of the CSR matrix engine.
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam int unsigned CSM_MAX_DIM = 1024;
  localparam int unsigned CSM_MAX_NZ  = 8192;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned ROW_W  = 11;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned SLOT_W = 14;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned CFG_AW = 1;

  localparam logic [CFG_AW-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_NUM_COLS = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ROW_START = 3'd0,
    FN_NONZERO   = 3'd1,
    FN_VECTOR    = 3'd2,
    FN_ADD       = 3'd3,
    FN_CLEAR     = 3'd4,
    FN_MATVEC    = 3'd5,
    FN_MATVEC_T  = 3'd6,
    FN_READ      = 3'd7
  } func_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LD_RS,
    OP_LD_NZ,
    OP_LD_VEC,
    OP_RD_PROD,
    OP_RS_ROW,
    OP_RS_ROW1,
    OP_RS_HI,
    OP_SEARCH_RD,
    OP_SEARCH_CMP,
    OP_RS_ROWS,
    OP_CLR_HI,
    OP_CLR_VAL,
    OP_RS_I,
    OP_RS_I1,
    OP_ROW_HI,
    OP_NZ_RD,
    OP_VEC_RD,
    OP_MUL_X,
    OP_ACC,
    OP_ROW_END,
    OP_ACLR,
    OP_I_ZERO,
    OP_I_INC,
    OP_T_COL,
    OP_T_ACC,
    OP_F_RD,
    OP_F_WR,
    OP_FIN,
    OP_FIN_RD
  } dp_op_e;

  typedef struct packed {
    logic add_ok;
    logic j_lt_hi;
    logic i_lt_rows;
    logic i_lt_cols;
    logic col_hit;
    logic col_lt_cols;
  } dp_status_t;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic signed [31:0] narrow_q16(logic signed [63:0] x);
    logic signed [47:0] q;
    logic signed [31:0] r;
    q = 48'(x >>> 16);
    if (q > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (q < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = q[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add32(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/csm_if.sv -----
// ----------------------------------------------------------------------------
// csm_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface csm_in_if;
  logic                             valid;
  logic                             ready;
  logic [csm_pkg::FUNC_W-1:0]       func;
  logic [csm_pkg::ROW_W-1:0]        row;
  logic [csm_pkg::COL_W-1:0]        col;
  logic [csm_pkg::SLOT_W-1:0]       slot;
  logic signed [csm_pkg::VAL_W-1:0] val;

  modport source (output valid, func, row, col, slot, val, input ready);
  modport sink (input valid, func, row, col, slot, val, output ready);
endinterface

interface csm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [csm_pkg::VAL_W-1:0] result;
  logic                             found;

  modport source (output valid, result, found, input ready);
  modport sink (input valid, result, found, output ready);
endinterface

// ----- rtl/core/csr_sparse_matvec_engine.sv -----
// ----------------------------------------------------------------------------
// csr_sparse_matvec_engine
// CSR sparse matrix engine in Q16.16: loads, value add by binary search,
// clear of the stored values, y = A*x and y = transpose(A)*x into a product
// store, and product read-back. An add outside num_rows/num_cols does no
// search; a search that misses leaves the values unchanged. transpose(A)*x
// clears the column sums, adds in each nonzero whose column is in range, and
// then narrows the sums into the product store.
// An item finishes only once the output slot is free of the previous result.
// One item in work at a time, set by the sequencer, which accepts only when idle.
// Reset clears control, num_rows = num_cols = 1; stores are not initialized.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_engine #(
  parameter int unsigned MAX_DIM      = csm_pkg::CSM_MAX_DIM,
  parameter int unsigned MAX_NONZEROS = csm_pkg::CSM_MAX_NZ
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [csm_pkg::CFG_AW-1:0]  cfg_idx_i,
  input  logic [csm_pkg::CFG_W-1:0]   cfg_data_i,
  csm_in_if.sink                      in_i,
  csm_out_if.source                   out_o
);
  import csm_pkg::*;

  dp_op_e     op;
  dp_status_t status;

  csm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_func_i   (func_e'(in_i.func)),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .op_o        (op)
  );

  csm_dpath #(
    .MAX_DIM (MAX_DIM),
    .MAX_NZ  (MAX_NONZEROS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .row_i      (in_i.row),
    .col_i      (in_i.col),
    .slot_i     (in_i.slot),
    .val_i      (in_i.val),
    .result_o   (out_o.result),
    .found_o    (out_o.found)
  );

endmodule

// ----- rtl/core/csm_dpath.sv -----
// ----------------------------------------------------------------------------
// csm_dpath
// Stores, index registers, multiplier and accumulator of the CSR engine.
// ----------------------------------------------------------------------------
module csm_dpath #(
  parameter int unsigned MAX_DIM = csm_pkg::CSM_MAX_DIM,
  parameter int unsigned MAX_NZ  = csm_pkg::CSM_MAX_NZ
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  csm_pkg::dp_op_e                  op_i,
  output csm_pkg::dp_status_t              status_o,
  input  logic                             cfg_we_i,
  input  logic [csm_pkg::CFG_AW-1:0]       cfg_idx_i,
  input  logic [csm_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic [csm_pkg::ROW_W-1:0]        row_i,
  input  logic [csm_pkg::COL_W-1:0]        col_i,
  input  logic [csm_pkg::SLOT_W-1:0]       slot_i,
  input  logic signed [csm_pkg::VAL_W-1:0] val_i,
  output logic signed [csm_pkg::VAL_W-1:0] result_o,
  output logic                             found_o
);
  import csm_pkg::*;

  localparam int unsigned DAW = $clog2(MAX_DIM);
  localparam int unsigned RW  = $clog2(MAX_DIM + 1);
  localparam int unsigned NAW = $clog2(MAX_NZ);
  localparam int unsigned PW  = $clog2(MAX_NZ + 1);

  logic [SLOT_W-1:0]       rs_mem   [MAX_DIM+1];
  logic [COL_W-1:0]        col_mem  [MAX_NZ];
  logic signed [31:0]      val_mem  [MAX_NZ];
  logic signed [31:0]      vec_mem  [MAX_DIM];
  logic signed [31:0]      prd_mem  [MAX_DIM];
  logic signed [63:0]      acc_mem  [MAX_DIM];

  logic [CFG_W-1:0]        num_rows_q, num_cols_q;
  logic [ROW_W-1:0]        row_q;
  logic [COL_W-1:0]        col_q;
  logic [SLOT_W-1:0]       slot_q;
  logic signed [31:0]      val_q;
  logic [RW-1:0]           i_q;
  logic [PW-1:0]           j_q, hi_q;
  logic [NAW-1:0]          mid_q, mid_d;
  logic signed [63:0]      acc_q, prod_q;
  logic signed [31:0]      xi_q;
  logic                    xok_q, found_q;
  logic signed [31:0]      res_q;
  logic                    fnd_q;

  logic [SLOT_W-1:0]       rs_rd_q;
  logic [COL_W-1:0]        col_rd_q;
  logic signed [31:0]      val_rd_q, vec_rd_q, prd_rd_q;
  logic signed [63:0]      acc_rd_q;

  logic [RW-1:0]           rows_used, cols_used;
  logic [PW-1:0]           ptr;
  logic [PW:0]             msum;
  logic signed [31:0]      mul_b;
  logic signed [63:0]      mul_p;

  logic                    rs_we, rs_re, nz_we, col_we, nz_re, vec_we, vec_re;
  logic                    prd_we, prd_re, acc_we, acc_re;
  logic [RW-1:0]           rs_wa, rs_ra;
  logic [NAW-1:0]          nz_wa, nz_ra;
  logic signed [31:0]      val_wd, prd_wd;
  logic [DAW-1:0]          vec_wa, vec_ra, prd_wa, prd_ra, acc_wa, acc_ra;
  logic signed [63:0]      acc_wd;

  assign rows_used = (32'(num_rows_q) > 32'(MAX_DIM)) ? RW'(MAX_DIM) : RW'(num_rows_q);
  assign cols_used = (32'(num_cols_q) > 32'(MAX_DIM)) ? RW'(MAX_DIM) : RW'(num_cols_q);
  assign ptr       = (32'(rs_rd_q) > 32'(MAX_NZ)) ? PW'(MAX_NZ) : PW'(rs_rd_q);
  assign msum      = {1'b0, j_q} + {1'b0, hi_q} - 1'b1;
  assign mid_d     = NAW'(msum >> 1);
  assign mul_b     = (op_i == OP_MUL_X) ? (xok_q ? vec_rd_q : 32'sd0) : xi_q;
  assign mul_p     = val_rd_q * mul_b;

  assign status_o.add_ok      = (32'(row_q) < 32'(rows_used)) &&
                                (32'(col_q) < 32'(cols_used));
  assign status_o.j_lt_hi     = j_q < hi_q;
  assign status_o.i_lt_rows   = i_q < rows_used;
  assign status_o.i_lt_cols   = i_q < cols_used;
  assign status_o.col_hit     = col_rd_q == col_q;
  assign status_o.col_lt_cols = 32'(col_rd_q) < 32'(cols_used);

  assign result_o = res_q;
  assign found_o  = fnd_q;

  always_comb begin
    rs_we  = 1'b0;
    rs_re  = 1'b0;
    nz_we  = 1'b0;
    col_we = 1'b0;
    nz_re  = 1'b0;
    vec_we = 1'b0;
    vec_re = 1'b0;
    prd_we = 1'b0;
    prd_re = 1'b0;
    acc_we = 1'b0;
    acc_re = 1'b0;
    rs_wa  = RW'(row_q);
    rs_ra  = i_q;
    nz_wa  = NAW'(slot_q);
    nz_ra  = NAW'(j_q);
    val_wd = val_q;
    vec_wa = DAW'(slot_q);
    vec_ra = DAW'(i_q);
    prd_wa = DAW'(i_q);
    prd_ra = DAW'(slot_q);
    prd_wd = narrow_q16(acc_q);
    acc_wa = DAW'(col_rd_q);
    acc_ra = DAW'(col_rd_q);
    acc_wd = sat_add64(acc_rd_q, prod_q);
    case (op_i)
      OP_LD_RS: begin
        rs_we = 32'(row_q) <= 32'(MAX_DIM);
      end
      OP_LD_NZ: begin
        nz_we  = 32'(slot_q) < 32'(MAX_NZ);
        col_we = 32'(slot_q) < 32'(MAX_NZ);
      end
      OP_LD_VEC: begin
        vec_we = 32'(slot_q) < 32'(MAX_DIM);
      end
      OP_RD_PROD: begin
        prd_re = 1'b1;
      end
      OP_RS_ROW: begin
        rs_re = 1'b1;
        rs_ra = RW'(row_q);
      end
      OP_RS_ROW1: begin
        rs_re = 1'b1;
        rs_ra = RW'(32'(row_q) + 32'd1);
      end
      OP_SEARCH_RD: begin
        nz_re = 1'b1;
        nz_ra = mid_d;
      end
      OP_SEARCH_CMP: begin
        nz_we  = col_rd_q == col_q;
        nz_wa  = mid_q;
        val_wd = sat_add32(val_rd_q, val_q);
      end
      OP_RS_ROWS: begin
        rs_re = 1'b1;
        rs_ra = rows_used;
      end
      OP_CLR_VAL: begin
        nz_we  = 1'b1;
        nz_wa  = NAW'(j_q);
        val_wd = 32'sd0;
      end
      OP_RS_I: begin
        rs_re  = 1'b1;
        vec_re = 1'b1;
      end
      OP_RS_I1: begin
        rs_re = 1'b1;
        rs_ra = RW'(32'(i_q) + 32'd1);
      end
      OP_NZ_RD: begin
        nz_re = 1'b1;
      end
      OP_VEC_RD: begin
        vec_re = 1'b1;
        vec_ra = DAW'(col_rd_q);
      end
      OP_ROW_END: begin
        prd_we = 1'b1;
      end
      OP_ACLR: begin
        acc_we = 1'b1;
        acc_wa = DAW'(i_q);
        acc_wd = 64'sd0;
      end
      OP_T_COL: begin
        acc_re = status_o.col_lt_cols;
      end
      OP_T_ACC: begin
        acc_we = 1'b1;
      end
      OP_F_RD: begin
        acc_re = 1'b1;
        acc_ra = DAW'(i_q);
      end
      OP_F_WR: begin
        prd_we = 1'b1;
        prd_wd = narrow_q16(acc_rd_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rs_wa] <= slot_q;
    end
    if (rs_re) begin
      rs_rd_q <= rs_mem[rs_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[nz_wa] <= col_q;
    end
    if (nz_re) begin
      col_rd_q <= col_mem[nz_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nz_we) begin
      val_mem[nz_wa] <= val_wd;
    end
    if (nz_re) begin
      val_rd_q <= val_mem[nz_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[vec_wa] <= val_q;
    end
    if (vec_re) begin
      vec_rd_q <= vec_mem[vec_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prd_we) begin
      prd_mem[prd_wa] <= prd_wd;
    end
    if (prd_re) begin
      prd_rd_q <= prd_mem[prd_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    if (acc_re) begin
      acc_rd_q <= acc_mem[acc_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= CFG_W'(1);
      num_cols_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NUM_ROWS) begin
        num_rows_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_NUM_COLS) begin
        num_cols_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_CAPTURE: begin
        row_q   <= row_i;
        col_q   <= col_i;
        slot_q  <= slot_i;
        val_q   <= val_i;
        i_q     <= '0;
        found_q <= 1'b0;
      end
      OP_RS_ROW1, OP_RS_I1: begin
        j_q  <= ptr;
        xi_q <= vec_rd_q;
      end
      OP_RS_HI: begin
        hi_q <= ptr;
      end
      OP_SEARCH_RD: begin
        mid_q <= mid_d;
      end
      OP_SEARCH_CMP: begin
        if (col_rd_q == col_q) begin
          found_q <= 1'b1;
        end else if (col_rd_q < col_q) begin
          j_q <= PW'(32'(mid_q) + 32'd1);
        end else begin
          hi_q <= PW'(mid_q);
        end
      end
      OP_CLR_HI: begin
        hi_q <= ptr;
        j_q  <= '0;
      end
      OP_CLR_VAL, OP_ACC, OP_T_ACC: begin
        j_q <= j_q + 1'b1;
        if (op_i == OP_ACC) begin
          acc_q <= sat_add64(acc_q, prod_q);
        end
      end
      OP_ROW_HI: begin
        hi_q  <= ptr;
        acc_q <= 64'sd0;
      end
      OP_VEC_RD: begin
        xok_q <= 32'(col_rd_q) < 32'(MAX_DIM);
      end
      OP_MUL_X: begin
        prod_q <= mul_p;
      end
      OP_T_COL: begin
        prod_q <= mul_p;
        if (!status_o.col_lt_cols) begin
          j_q <= j_q + 1'b1;
        end
      end
      OP_ROW_END, OP_ACLR, OP_I_INC, OP_F_WR: begin
        i_q <= i_q + 1'b1;
      end
      OP_I_ZERO: begin
        i_q <= '0;
      end
      OP_FIN: begin
        res_q <= 32'sd0;
        fnd_q <= found_q;
      end
      OP_FIN_RD: begin
        res_q <= (32'(slot_q) < 32'(MAX_DIM)) ? prd_rd_q : 32'sd0;
        fnd_q <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/csm_ctrl.sv -----
// ----------------------------------------------------------------------------
// csm_ctrl
// Sequencer of the CSR engine: decodes items and steps the datapath.
// ----------------------------------------------------------------------------
module csm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  csm_pkg::func_e      in_func_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  csm_pkg::dp_status_t status_i,
  output csm_pkg::dp_op_e     op_o
);
  import csm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_RS, S_LD_NZ, S_LD_VEC, S_RD, S_FIN, S_FIN_RD,
    S_ADD_P0, S_ADD_P1, S_ADD_P2, S_ADD_LOOP, S_ADD_CMP,
    S_CLR_P0, S_CLR_P1, S_CLR_LOOP,
    S_MX_R0, S_MX_R1, S_MX_R2, S_MX_NZ, S_MX_VEC, S_MX_MUL, S_MX_ACC, S_MX_END,
    S_TX_ACLR, S_TX_R0, S_TX_R1, S_TX_R2, S_TX_NZ, S_TX_COL, S_TX_ACC,
    S_TX_F0, S_TX_F1
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_CAPTURE;
          case (in_func_i)
            FN_ROW_START: state_d = S_LD_RS;
            FN_NONZERO:   state_d = S_LD_NZ;
            FN_VECTOR:    state_d = S_LD_VEC;
            FN_ADD:       state_d = S_ADD_P0;
            FN_CLEAR:     state_d = S_CLR_P0;
            FN_MATVEC:    state_d = S_MX_R0;
            FN_MATVEC_T:  state_d = S_TX_ACLR;
            FN_READ:      state_d = S_RD;
            default:      state_d = S_FIN;
          endcase
        end
      end
      S_LD_RS: begin
        op_o = OP_LD_RS;
        state_d = S_FIN;
      end
      S_LD_NZ: begin
        op_o = OP_LD_NZ;
        state_d = S_FIN;
      end
      S_LD_VEC: begin
        op_o = OP_LD_VEC;
        state_d = S_FIN;
      end
      S_RD: begin
        op_o = OP_RD_PROD;
        state_d = S_FIN_RD;
      end
      S_FIN: begin
        if (slot_free) begin
          op_o = OP_FIN;
          state_d = S_IDLE;
        end
      end
      S_FIN_RD: begin
        if (slot_free) begin
          op_o = OP_FIN_RD;
          state_d = S_IDLE;
        end
      end
      S_ADD_P0: begin
        op_o = OP_RS_ROW;
        state_d = status_i.add_ok ? S_ADD_P1 : S_FIN;
      end
      S_ADD_P1: begin
        op_o = OP_RS_ROW1;
        state_d = S_ADD_P2;
      end
      S_ADD_P2: begin
        op_o = OP_RS_HI;
        state_d = S_ADD_LOOP;
      end
      S_ADD_LOOP: begin
        if (status_i.j_lt_hi) begin
          op_o = OP_SEARCH_RD;
          state_d = S_ADD_CMP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ADD_CMP: begin
        op_o = OP_SEARCH_CMP;
        state_d = status_i.col_hit ? S_FIN : S_ADD_LOOP;
      end
      S_CLR_P0: begin
        op_o = OP_RS_ROWS;
        state_d = S_CLR_P1;
      end
      S_CLR_P1: begin
        op_o = OP_CLR_HI;
        state_d = S_CLR_LOOP;
      end
      S_CLR_LOOP: begin
        if (status_i.j_lt_hi) begin
          op_o = OP_CLR_VAL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MX_R0: begin
        if (status_i.i_lt_rows) begin
          op_o = OP_RS_I;
          state_d = S_MX_R1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MX_R1: begin
        op_o = OP_RS_I1;
        state_d = S_MX_R2;
      end
      S_MX_R2: begin
        op_o = OP_ROW_HI;
        state_d = S_MX_NZ;
      end
      S_MX_NZ: begin
        if (status_i.j_lt_hi) begin
          op_o = OP_NZ_RD;
          state_d = S_MX_VEC;
        end else begin
          state_d = S_MX_END;
        end
      end
      S_MX_VEC: begin
        op_o = OP_VEC_RD;
        state_d = S_MX_MUL;
      end
      S_MX_MUL: begin
        op_o = OP_MUL_X;
        state_d = S_MX_ACC;
      end
      S_MX_ACC: begin
        op_o = OP_ACC;
        state_d = S_MX_NZ;
      end
      S_MX_END: begin
        op_o = OP_ROW_END;
        state_d = S_MX_R0;
      end
      S_TX_ACLR: begin
        if (status_i.i_lt_cols) begin
          op_o = OP_ACLR;
        end else begin
          op_o = OP_I_ZERO;
          state_d = S_TX_R0;
        end
      end
      S_TX_R0: begin
        if (status_i.i_lt_rows) begin
          op_o = OP_RS_I;
          state_d = S_TX_R1;
        end else begin
          op_o = OP_I_ZERO;
          state_d = S_TX_F0;
        end
      end
      S_TX_R1: begin
        op_o = OP_RS_I1;
        state_d = S_TX_R2;
      end
      S_TX_R2: begin
        op_o = OP_ROW_HI;
        state_d = S_TX_NZ;
      end
      S_TX_NZ: begin
        if (status_i.j_lt_hi) begin
          op_o = OP_NZ_RD;
          state_d = S_TX_COL;
        end else begin
          op_o = OP_I_INC;
          state_d = S_TX_R0;
        end
      end
      S_TX_COL: begin
        op_o = OP_T_COL;
        state_d = status_i.col_lt_cols ? S_TX_ACC : S_TX_NZ;
      end
      S_TX_ACC: begin
        op_o = OP_T_ACC;
        state_d = S_TX_NZ;
      end
      S_TX_F0: begin
        if (status_i.i_lt_cols) begin
          op_o = OP_F_RD;
          state_d = S_TX_F1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_TX_F1: begin
        op_o = OP_F_WR;
        state_d = S_TX_F0;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (op_o == OP_FIN || op_o == OP_FIN_RD) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/csm_checker.sv -----
// ----------------------------------------------------------------------------
// csm_checker
// Port-level checks of the CSR engine, bound to the top level.
// ----------------------------------------------------------------------------
module csm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result,
  input logic        out_found
);
  logic [1:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_result) && $stable(out_found))
    else $error("result changed while stalled");

  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items in flight");

  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_found |-> out_result == 32'd0)
    else $error("add result carries nonzero value");

endmodule

bind csr_sparse_matvec_engine csm_checker u_csm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_result (out_o.result),
  .out_found  (out_o.found)
);

// ----- tb/sv/csr_sparse_matvec_engine_tb.sv -----
// ----------------------------------------------------------------------------
// csr_sparse_matvec_engine_tb
// Self-checking bench for the CSR matrix engine: builds well-formed sparse
// matrices with random content, runs adds, clears, A*x, transpose(A)*x and
// read-back, and checks every result against a built-in Q16.16 predictor.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csm_pkg::*;

  typedef struct {
    logic signed [31:0] result;
    logic               found;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_AW-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;

  csm_in_if  req_if ();
  csm_out_if rsp_if ();

  csr_sparse_matvec_engine i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if.sink),
    .out_o      (rsp_if.source)
  );

  // predictor state
  logic [13:0]        row_ptr_m [0:1024];
  logic [9:0]         nz_col_m  [0:8191];
  logic signed [31:0] nz_val_m  [0:8191];
  logic signed [31:0] x_vec_m   [0:1023];
  logic signed [31:0] y_vec_m   [0:1023];
  longint             col_sum_m [0:1023];
  bit                 y_written [0:1023];
  logic [10:0]        rows_reg;
  logic [10:0]        cols_reg;

  outcome_t pending_q[$];
  int       mismatches;
  int       src_idle_pct;
  int       snk_idle_pct;
  int       hold_cycles;
  int       cur_rows, cur_nnz, cur_width;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned ptr_at(int unsigned r);
    return (row_ptr_m[r] > 8192) ? 8192 : row_ptr_m[r];
  endfunction

  function automatic int unsigned rows_in_use();
    return (rows_reg > 1024) ? 1024 : rows_reg;
  endfunction

  function automatic int unsigned cols_in_use();
    return (cols_reg > 1024) ? 1024 : cols_reg;
  endfunction

  function automatic longint add_sat64(longint a, longint b);
    longint s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] to_q16(longint x);
    return clamp32(x >>> 16);
  endfunction

  function automatic outcome_t predict_outcome(func_e fn, logic [10:0] row, logic [9:0] col,
                                               logic [13:0] slot, logic signed [31:0] v);
    outcome_t    o;
    int unsigned lo, hi, mid, s, e;
    longint      acc, x;
    o.result = '0;
    o.found  = 1'b0;
    case (fn)
      FN_ROW_START: if (row <= 1024) row_ptr_m[row] = slot;
      FN_NONZERO: begin
        if (slot < 8192) begin
          nz_col_m[slot] = col;
          nz_val_m[slot] = v;
        end
      end
      FN_VECTOR: if (slot < 1024) x_vec_m[slot] = v;
      FN_ADD: begin
        if (row < rows_in_use() && col < cols_in_use()) begin
          lo = ptr_at(row);
          hi = ptr_at(row + 1);
          while (lo < hi && !o.found) begin
            mid = (lo + hi - 1) / 2;
            if (nz_col_m[mid] == col) begin
              nz_val_m[mid] = clamp32(longint'(nz_val_m[mid]) + longint'(v));
              o.found = 1'b1;
            end else if (nz_col_m[mid] < col) begin
              lo = mid + 1;
            end else begin
              hi = mid;
            end
          end
        end
      end
      FN_CLEAR: for (int unsigned i = 0; i < ptr_at(rows_in_use()); i++) nz_val_m[i] = '0;
      FN_MATVEC: begin
        for (int unsigned i = 0; i < rows_in_use(); i++) begin
          acc = 0;
          s = ptr_at(i);
          e = ptr_at(i + 1);
          for (int unsigned j = s; j < e; j++) begin
            x = longint'(x_vec_m[nz_col_m[j]]);
            acc = add_sat64(acc, longint'(nz_val_m[j]) * x);
          end
          y_vec_m[i] = to_q16(acc);
        end
      end
      FN_MATVEC_T: begin
        for (int unsigned i = 0; i < cols_in_use(); i++) col_sum_m[i] = 0;
        for (int unsigned i = 0; i < rows_in_use(); i++) begin
          s = ptr_at(i);
          e = ptr_at(i + 1);
          for (int unsigned j = s; j < e; j++) begin
            if (nz_col_m[j] < cols_in_use()) begin
              col_sum_m[nz_col_m[j]] = add_sat64(col_sum_m[nz_col_m[j]],
                  longint'(nz_val_m[j]) * longint'(x_vec_m[i]));
            end
          end
        end
        for (int unsigned i = 0; i < cols_in_use(); i++) y_vec_m[i] = to_q16(col_sum_m[i]);
      end
      default: if (slot < 1024) o.result = y_vec_m[slot];
    endcase
    return o;
  endfunction

  // sink side: random back-pressure plus long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    outcome_t exp_o;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h found %b", rsp_if.result,
                                       rsp_if.found);
      end else begin
        exp_o = pending_q.pop_front();
        if (rsp_if.result !== exp_o.result || rsp_if.found !== exp_o.found) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: result exp %h got %h, found exp %b got %b",
                     exp_o.result, rsp_if.result, exp_o.found, rsp_if.found);
          end
        end
      end
    end
  end

  task automatic send_item(func_e fn, logic [10:0] row, logic [9:0] col, logic [13:0] slot,
                           logic signed [31:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= fn;
    req_if.row   <= row;
    req_if.col   <= col;
    req_if.slot  <= slot;
    req_if.val   <= v;
    do @(posedge clk_i); while (!req_if.ready);
    pending_q.push_back(predict_outcome(fn, row, col, slot, v));
    if (fn == FN_MATVEC) for (int i = 0; i < rows_in_use(); i++) y_written[i] = 1'b1;
    if (fn == FN_MATVEC_T) for (int i = 0; i < cols_in_use(); i++) y_written[i] = 1'b1;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [10:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_NUM_ROWS) rows_reg = data;
    else cols_reg = data;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(131072))) - 32'sh1_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic read_product();
    int unsigned s;
    s = $urandom_range(1023);
    if ($urandom_range(3) == 0 || !y_written[s % 16]) begin
      send_item(FN_READ, 11'($urandom), 10'($urandom), 14'(1024 + $urandom_range(15359)),
                $urandom);
    end else begin
      send_item(FN_READ, 11'($urandom), 10'($urandom), 14'(s % 16), $urandom);
    end
  endtask

  // well-formed CSR matrix: sorted unique columns per row, vector covers all columns
  task automatic load_matrix(int rows, int cols);
    int unsigned ptr [0:16];
    int unsigned c;
    drain();
    write_reg(CFG_NUM_ROWS, 11'(rows));
    write_reg(CFG_NUM_COLS, 11'(cols));
    cur_rows  = rows;
    cur_width = cols + 2;
    cur_nnz   = 0;
    for (int r = 0; r < rows; r++) begin
      ptr[r] = cur_nnz;
      c = $urandom_range(1);
      while (c < cur_width && $urandom_range(4) != 0) begin
        send_item(FN_NONZERO, 11'($urandom), 10'(c), 14'(cur_nnz), pick_value());
        cur_nnz++;
        c += 1 + $urandom_range(2);
      end
    end
    ptr[rows] = cur_nnz;
    for (int r = 0; r <= rows; r++) begin
      send_item(FN_ROW_START, 11'(r), 10'($urandom), 14'(ptr[r]), $urandom);
    end
    for (int i = 0; i < ((rows > cur_width) ? rows : cur_width); i++) begin
      send_item(FN_VECTOR, 11'($urandom), 10'($urandom), 14'(i), pick_value());
    end
  endtask

  task automatic random_item();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 30) begin
      send_item(FN_ADD, ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(cur_rows)),
                ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(cur_width)),
                14'($urandom), pick_value());
    end else if (p < 40) begin
      send_item(FN_MATVEC, 11'($urandom), 10'($urandom), 14'($urandom), $urandom);
    end else if (p < 48) begin
      send_item(FN_MATVEC_T, 11'($urandom), 10'($urandom), 14'($urandom), $urandom);
    end else if (p < 54) begin
      send_item(FN_CLEAR, 11'($urandom), 10'($urandom), 14'($urandom), $urandom);
    end else if (p < 80) begin
      read_product();
    end else if (p < 86) begin
      if ($urandom_range(1)) send_item(FN_ROW_START, 11'($urandom_range(cur_rows)),
                                        10'($urandom), 14'($urandom_range(cur_nnz)), $urandom);
      else send_item(FN_ROW_START, 11'($urandom_range(2047, 1025)), 10'($urandom),
                     14'($urandom), $urandom);
    end else if (p < 93) begin
      if ($urandom_range(1) && cur_nnz > 0) send_item(FN_NONZERO, 11'($urandom),
          10'($urandom_range(cur_width - 1)), 14'($urandom_range(cur_nnz - 1)), pick_value());
      else send_item(FN_NONZERO, 11'($urandom), 10'($urandom),
                     14'($urandom_range(16383, 8192)), $urandom);
    end else begin
      if ($urandom_range(1)) send_item(FN_VECTOR, 11'($urandom), 10'($urandom),
                                        14'($urandom_range(cur_width - 1)), pick_value());
      else send_item(FN_VECTOR, 11'($urandom), 10'($urandom),
                     14'($urandom_range(16383, 1024)), $urandom);
    end
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(CFG_NUM_ROWS, 11'd2);
    write_reg(CFG_NUM_COLS, 11'd3);
    cur_rows = 2; cur_width = 5; cur_nnz = 3;
    send_item(FN_NONZERO, '0, 10'd0, 14'd0, 32'sh7FFF_FFFF);
    send_item(FN_NONZERO, '0, 10'd2, 14'd1, 32'sh8000_0000);
    send_item(FN_NONZERO, '0, 10'd1, 14'd2, 32'sh0001_0000);
    send_item(FN_ROW_START, 11'd0, '0, 14'd0, '0);
    send_item(FN_ROW_START, 11'd1, '0, 14'd2, '0);
    send_item(FN_ROW_START, 11'd2, '0, 14'd3, '0);
    for (int i = 0; i < 5; i++) send_item(FN_VECTOR, '0, '0, 14'(i), (i % 2) ? 32'sh8000_0000
                                                                            : 32'sh7FFF_FFFF);
    send_item(FN_MATVEC, '0, '0, '0, '0);
    send_item(FN_READ, '0, '0, 14'd0, '0);
    send_item(FN_READ, '0, '0, 14'd1, '0);
    send_item(FN_ADD, 11'd0, 10'd0, '0, 32'sh7FFF_FFFF);
    send_item(FN_ADD, 11'd0, 10'd1, '0, 32'sh0000_0001);
    send_item(FN_ADD, 11'd2, 10'd0, '0, 32'sh0000_0001);
    send_item(FN_ADD, 11'd1, 10'd1, '0, 32'sh8000_0000);
    send_item(FN_ADD, 11'd0, 10'd3, '0, 32'sh0000_0001);
    send_item(FN_MATVEC_T, '0, '0, '0, '0);
    send_item(FN_READ, '0, '0, 14'd2, '0);
    send_item(FN_READ, 11'h7FF, 10'h3FF, 14'h3FFF, 32'shFFFF_FFFF);
    send_item(FN_CLEAR, '0, '0, '0, '0);
    send_item(FN_ROW_START, 11'd2, '0, 14'd1, '0);
    send_item(FN_MATVEC, '0, '0, '0, '0);
    send_item(FN_READ, '0, '0, 14'd1, '0);
    send_item(FN_ROW_START, 11'd1024, '0, 14'd8192, '0);
    drain();
  endtask

  task automatic test_random_phase(int src_pct, int snk_pct, int n_items);
    int done;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    done = 0;
    while (done < n_items) begin
      load_matrix($urandom_range(1, 12), $urandom_range(1, 12));
      repeat (40) begin
        random_item();
        done++;
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    load_matrix(4, 4);
    hold_cycles = 300;
    repeat (30) begin
      send_item(FN_READ, 11'($urandom), 10'($urandom), 14'(1024 + $urandom_range(100)), '0);
    end
    drain();
  endtask

  task automatic test_full_size();
    src_idle_pct = 0;
    snk_idle_pct = 10;
    write_reg(CFG_NUM_ROWS, 11'd2047);
    write_reg(CFG_NUM_COLS, 11'd2047);
    send_item(FN_NONZERO, '0, 10'd0, 14'd0, pick_value());
    send_item(FN_NONZERO, '0, 10'd1023, 14'd1, pick_value());
    send_item(FN_NONZERO, '0, 10'd5, 14'd2, pick_value());
    send_item(FN_ROW_START, 11'd0, '0, 14'd0, '0);
    send_item(FN_ROW_START, 11'd1, '0, 14'd2, '0);
    send_item(FN_ROW_START, 11'd2, '0, 14'd3, '0);
    send_item(FN_ROW_START, 11'd1023, '0, 14'd3, '0);
    send_item(FN_ROW_START, 11'd1024, '0, 14'd3, '0);
    send_item(FN_VECTOR, '0, '0, 14'd0, pick_value());
    send_item(FN_VECTOR, '0, '0, 14'd1, pick_value());
    send_item(FN_VECTOR, '0, '0, 14'd5, pick_value());
    send_item(FN_VECTOR, '0, '0, 14'd1023, pick_value());
    send_item(FN_ADD, 11'd0, 10'd1023, '0, 32'sh7FFF_FFFF);
    send_item(FN_ADD, 11'd1023, 10'd5, '0, 32'sh7FFF_FFFF);
    send_item(FN_ADD, 11'd1024, 10'd5, '0, 32'sh7FFF_FFFF);
    send_item(FN_ADD, 11'd1, 10'd5, '0, 32'sh8000_0000);
    drain();
    write_reg(CFG_NUM_ROWS, 11'd2);
    send_item(FN_MATVEC, '0, '0, '0, '0);
    send_item(FN_READ, '0, '0, 14'd0, '0);
    send_item(FN_READ, '0, '0, 14'd1, '0);
    send_item(FN_MATVEC_T, '0, '0, '0, '0);
    send_item(FN_READ, '0, '0, 14'd1023, '0);
    send_item(FN_READ, '0, '0, 14'd5, '0);
    send_item(FN_CLEAR, '0, '0, '0, '0);
    send_item(FN_MATVEC, '0, '0, '0, '0);
    send_item(FN_READ, '0, '0, 14'd1, '0);
    drain();
    write_reg(CFG_NUM_COLS, 11'd1024);
    send_item(FN_MATVEC_T, '0, '0, '0, '0);
    send_item(FN_READ, '0, '0, 14'd1023, '0);
    drain();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.func  = '0;
    req_if.row   = '0;
    req_if.col   = '0;
    req_if.slot  = '0;
    req_if.val   = '0;
    rows_reg     = 11'd1;
    cols_reg     = 11'd1;
    mismatches   = 0;
    hold_cycles  = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_phase(24, 48, 140);
    test_random_phase(48, 24, 140);
    test_random_phase(0, 0, 140);
    test_full_size();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/csm_pkg.sv
rtl/core/csm_if.sv
rtl/core/csm_dpath.sv
rtl/core/csm_ctrl.sv
rtl/core/csr_sparse_matvec_engine.sv
rtl/core/csm_checker.sv
tb/sv/csr_sparse_matvec_engine_tb.sv
